[hdl/psrs_pkg.sv]
// Package for the per-source reorder sequencer.
// Holds the window geometry, the queued item type and the slot index helpers.
// No dependencies.
package psrs_pkg;

  localparam int WINDOW      = 16;
  localparam int NUM_SOURCES = 8;
  localparam int MAX_RESULTS = 16;
  localparam int RUN_MAX     = (MAX_RESULTS < WINDOW) ? MAX_RESULTS : WINDOW;

  localparam int SRC_W   = 3;
  localparam int SEQ_W   = 16;
  localparam int DATA_W  = 32;
  localparam int STAMP_W = 32;

  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SLOTS   = NUM_SOURCES * WINDOW;
  localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_DELIVER = 1'b0;
  localparam logic CMD_JOIN    = 1'b1;

  typedef struct packed {
    logic              command;
    logic [SRC_W-1:0]  source_id;
    logic [SEQ_W-1:0]  seq;
    logic [DATA_W-1:0] payload;
  } item_t;

  // Adds a slot offset to a ring head; both operands stay below WINDOW.
  function automatic logic [SLOT_W-1:0] ring_add(input logic [SLOT_W-1:0] head,
                                                 input logic [SLOT_W-1:0] offs);
    logic [SLOT_W:0] sum;
    sum = {1'b0, head} + {1'b0, offs};
    if (sum >= (SLOT_W+1)'(WINDOW)) begin
      sum = sum - (SLOT_W+1)'(WINDOW);
    end
    return sum[SLOT_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SRC_W-1:0]  src,
                                                  input logic [SLOT_W-1:0] phys);
    return ADDR_W'(int'(src) * WINDOW + int'(phys));
  endfunction

endpackage

[hdl/psrs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module psrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/psrs_front.sv]
// Front end of the reorder sequencer: accepts input transactions, drops
// those from unknown sources and queues the rest for the back end.
// Depends on psrs_pkg.
module psrs_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        command,
  input  logic [psrs_pkg::SRC_W-1:0]  source_id,
  input  logic [psrs_pkg::SEQ_W-1:0]  seq,
  input  logic [psrs_pkg::DATA_W-1:0] payload,
  output logic                        q_valid,
  output psrs_pkg::item_t             q_item,
  input  logic                        q_pop
);
  import psrs_pkg::*;

  item_t             queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;
  logic              known_src;

  assign in_ready  = (count != QCNT_W'(QUEUE_DEPTH));
  assign known_src = (int'(source_id) < NUM_SOURCES);
  assign push      = in_valid && in_ready && known_src;
  assign q_valid   = (count != '0);
  assign pop       = q_pop && q_valid;
  assign q_item    = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{command: command, source_id: source_id, seq: seq,
                         payload: payload};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/psrs_back.sv]
// Back end of the reorder sequencer: per-source ring windows, slot storage,
// the release sequencer and the output register.
// Depends on psrs_pkg and psrs_ram.
module psrs_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  psrs_pkg::item_t              q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [psrs_pkg::SRC_W-1:0]   out_source,
  output logic [psrs_pkg::STAMP_W-1:0] global_seq,
  output logic [psrs_pkg::DATA_W-1:0]  out_payload,
  output logic                         last
);
  import psrs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]         state;
  logic [SEQ_W-1:0]   expected_seq [NUM_SOURCES];
  logic [SLOT_W-1:0]  head [NUM_SOURCES];
  logic [SLOTS-1:0]   slot_valid;
  logic [SLOTS-1:0]   slot_valid_next;
  logic [STAMP_W-1:0] global_stamp;

  logic [SRC_W-1:0]   rel_src;
  logic [SLOT_W-1:0]  rel_k;
  logic [ADDR_W-1:0]  rd_addr;

  // Classification of the item at the head of the queue.
  logic [SEQ_W-1:0]   gap;
  logic               in_window;
  logic [SLOT_W-1:0]  q_phys;
  logic [ADDR_W-1:0]  q_addr;
  logic               ram_we;

  // Release step.
  logic [SLOT_W:0]    run_len;
  logic [SLOT_W-1:0]  next_phys;
  logic               run_end;
  logic               load_out;
  logic [DATA_W-1:0]  ram_rdata;

  always_comb begin
    gap       = q_item.seq - expected_seq[q_item.source_id];
    in_window = (int'(gap) < WINDOW);
    q_phys    = ring_add(head[q_item.source_id], gap[SLOT_W-1:0]);
    q_addr    = slot_addr(q_item.source_id, q_phys);
    ram_we    = (state == ST_IDLE) && q_valid && (q_item.command == CMD_DELIVER) &&
                in_window;
    q_pop     = (state == ST_IDLE);

    run_len   = {1'b0, rel_k} + 1'b1;
    next_phys = ring_add(head[rel_src], run_len[SLOT_W-1:0]);
    // The run ends at the release limit or at the first gap in the window.
    run_end   = (run_len == (SLOT_W+1)'(RUN_MAX)) ||
                !slot_valid[slot_addr(rel_src, next_phys)];
    load_out  = (state == ST_WAIT) && (!out_valid || out_ready);
  end

  // A join clears the whole window of its source; an in-window delivery marks
  // its slot; each released item frees its slot.
  always_comb begin
    slot_valid_next = slot_valid;
    if ((state == ST_IDLE) && q_valid) begin
      if (q_item.command == CMD_JOIN) begin
        for (int k = 0; k < WINDOW; k++) begin
          slot_valid_next[slot_addr(q_item.source_id, SLOT_W'(k))] = 1'b0;
        end
      end else if (in_window) begin
        slot_valid_next[q_addr] = 1'b1;
      end
    end else if (load_out) begin
      slot_valid_next[rd_addr] = 1'b0;
    end
  end

  psrs_ram #(.WIDTH(DATA_W), .DEPTH(SLOTS)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_addr),
    .wdata (q_item.payload),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_source  <= rel_src;
      global_seq  <= global_stamp;
      out_payload <= ram_rdata;
      last        <= run_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slot_valid   <= '0;
      global_stamp <= '0;
      out_valid    <= 1'b0;
      rel_src      <= '0;
      rel_k        <= '0;
      rd_addr      <= '0;
      for (int s = 0; s < NUM_SOURCES; s++) begin
        expected_seq[s] <= '0;
        head[s]         <= '0;
      end
    end else begin
      slot_valid <= slot_valid_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_item.command == CMD_JOIN) begin
              expected_seq[q_item.source_id] <= '0;
              head[q_item.source_id]         <= '0;
            end else if (in_window) begin
              if (gap == '0) begin
                rel_src <= q_item.source_id;
                rel_k   <= '0;
                rd_addr <= q_addr;
                state   <= ST_READ;
              end
            end
          end
        end
        ST_READ: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (load_out) begin
            global_stamp           <= global_stamp + 1'b1;
            if (run_end) begin
              expected_seq[rel_src] <= expected_seq[rel_src] + SEQ_W'(run_len);
              head[rel_src]         <= (run_len == (SLOT_W+1)'(WINDOW)) ? head[rel_src]
                                                                        : next_phys;
              state                 <= ST_IDLE;
            end else begin
              rel_k   <= run_len[SLOT_W-1:0];
              rd_addr <= slot_addr(rel_src, next_phys);
              state   <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/per_source_reorder_sequencer.sv]
// Per-source reorder sequencer, top level: queueing front end and release back end.
// Path: an in-order message passes the front-end queue, READ and WAIT to out_valid.
// A message that releases nothing is taken in the idle state alone; each released item
// passes READ and WAIT, as the slot RAM read is registered; WAIT holds for a full output.
// Reset: synchronous, clears expected numbers, valid bits, stamp and queue; slot data
// needs no clearing.
module per_source_reorder_sequencer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         command,
  input  logic [psrs_pkg::SRC_W-1:0]   source_id,
  input  logic [psrs_pkg::SEQ_W-1:0]   seq,
  input  logic [psrs_pkg::DATA_W-1:0]  payload,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [psrs_pkg::SRC_W-1:0]   out_source,
  output logic [psrs_pkg::STAMP_W-1:0] global_seq,
  output logic [psrs_pkg::DATA_W-1:0]  out_payload,
  output logic                         last
);
  import psrs_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  psrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .source_id (source_id),
    .seq       (seq),
    .payload   (payload),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  psrs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_source  (out_source),
    .global_seq  (global_seq),
    .out_payload (out_payload),
    .last        (last)
  );

endmodule

[tb/sv/per_source_reorder_sequencer_test.sv]
// Testbench for per_source_reorder_sequencer: directed and random message traffic.
// A local window model predicts every release; a checker compares each output transaction.
// Depends on psrs_pkg and the per_source_reorder_sequencer RTL.
`timescale 1ns / 100ps

module per_source_reorder_sequencer_test;
  import psrs_pkg::*;

  localparam int STALL_PCT     = 36;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 50;
  localparam int RANDOM_ITEMS  = 120;

  typedef struct {
    logic [SRC_W-1:0]   src;
    logic [STAMP_W-1:0] stamp;
    logic [DATA_W-1:0]  data;
    logic               last;
  } release_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                command = CMD_DELIVER;
  logic [SRC_W-1:0]    source_id = '0;
  logic [SEQ_W-1:0]    seq = '0;
  logic [DATA_W-1:0]   payload = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SRC_W-1:0]    out_source;
  logic [STAMP_W-1:0]  global_seq;
  logic [DATA_W-1:0]   out_payload;
  logic                last;

  // Window model of the block.
  logic [SEQ_W-1:0]   next_seq [NUM_SOURCES];
  logic [DATA_W-1:0]  window_data [NUM_SOURCES][WINDOW];
  logic               window_valid [NUM_SOURCES][WINDOW];
  logic [STAMP_W-1:0] stamp_model;

  release_t pending_releases[$];
  int       mismatch_count = 0;
  int       idle_cycles = 0;
  bit       steady = 1'b0;

  per_source_reorder_sequencer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .source_id(source_id),
    .seq(seq),
    .payload(payload),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_source(out_source),
    .global_seq(global_seq),
    .out_payload(out_payload),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatch_count++;
    $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  task automatic clear_model;
    for (int s = 0; s < NUM_SOURCES; s++) begin
      next_seq[s] = '0;
      for (int k = 0; k < WINDOW; k++) begin
        window_valid[s][k] = 1'b0;
        window_data[s][k] = '0;
      end
    end
    stamp_model = '0;
  endtask

  // Applies one accepted transaction to the model and queues the releases it causes.
  task automatic apply_message(input item_t msg);
    logic [SEQ_W-1:0] gap;
    release_t         burst [RUN_MAX];
    int               n;
    int               src;
    src = int'(msg.source_id);
    if (msg.command == CMD_JOIN) begin
      next_seq[src] = '0;
      for (int k = 0; k < WINDOW; k++) begin
        window_valid[src][k] = 1'b0;
      end
    end else begin
      gap = msg.seq - next_seq[src];
      if (gap < WINDOW) begin
        window_data[src][gap[SLOT_W-1:0]] = msg.payload;
        window_valid[src][gap[SLOT_W-1:0]] = 1'b1;
        if (gap == 0) begin
          n = 0;
          while (n < WINDOW && n < MAX_RESULTS && window_valid[src][n]) begin
            burst[n].src = msg.source_id;
            burst[n].stamp = stamp_model;
            burst[n].data = window_data[src][n];
            burst[n].last = 1'b0;
            stamp_model = stamp_model + 1'b1;
            n++;
          end
          burst[n-1].last = 1'b1;
          for (int k = 0; k < n; k++) begin
            pending_releases.push_back(burst[k]);
          end
          next_seq[src] = next_seq[src] + SEQ_W'(n);
          for (int k = 0; k < WINDOW; k++) begin
            if (k + n < WINDOW) begin
              window_valid[src][k] = window_valid[src][k+n];
              window_data[src][k] = window_data[src][k+n];
            end else begin
              window_valid[src][k] = 1'b0;
            end
          end
        end
      end
    end
  endtask

  // Sends one transaction, idling at random first unless steady is set, and predicts it once accepted.
  task automatic send_message(input logic cmd, input logic [SRC_W-1:0] src,
                              input logic [SEQ_W-1:0] sq, input logic [DATA_W-1:0] pl);
    item_t msg;
    msg.command = cmd;
    msg.source_id = src;
    msg.seq = sq;
    msg.payload = pl;
    while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= msg.command;
    source_id <= msg.source_id;
    seq <= msg.seq;
    payload <= msg.payload;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    apply_message(msg);
  endtask

  // Sends offsets 0..m-1 above the expected number in shuffled order.
  task automatic send_shuffled_run(input logic [SRC_W-1:0] src, input int m);
    int               order [WINDOW];
    int               j;
    int               tmp;
    logic [SEQ_W-1:0] base;
    base = next_seq[src];
    for (int k = 0; k < m; k++) begin
      order[k] = k;
    end
    for (int k = m - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < m; k++) begin
      send_message(CMD_DELIVER, src, SEQ_W'(base + order[k]), $urandom);
      // An occasional resend of the same number with a new payload.
      if ($urandom_range(0, 9) == 0) begin
        send_message(CMD_DELIVER, src, SEQ_W'(base + order[k]), $urandom);
      end
    end
  endtask

  task automatic test_single_in_order;
    send_message(CMD_DELIVER, 3'd0, 16'd0, 32'hFFFF_FFFF);
  endtask

  task automatic test_reorder_and_overwrite;
    // The second message for seq 2 replaces the first one in its slot.
    send_message(CMD_DELIVER, 3'd1, 16'd2, 32'h1111_0002);
    send_message(CMD_DELIVER, 3'd1, 16'd2, 32'h2222_0002);
    send_message(CMD_DELIVER, 3'd1, 16'd1, 32'h0000_0001);
    send_message(CMD_DELIVER, 3'd1, 16'd0, 32'h0000_0000);
  endtask

  task automatic test_stale_and_far;
    send_message(CMD_DELIVER, 3'd1, 16'd1, $urandom);
    send_message(CMD_DELIVER, 3'd1, SEQ_W'(3 + WINDOW), $urandom);
    send_message(CMD_DELIVER, 3'd1, SEQ_W'(3 + WINDOW - 1), $urandom);
  endtask

  task automatic test_join;
    send_message(CMD_JOIN, 3'd1, 16'hFFFF, $urandom);
    send_message(CMD_DELIVER, 3'd1, 16'd0, 32'h0000_0000);
  endtask

  task automatic test_full_window;
    steady = 1'b1;
    for (int k = 1; k < WINDOW; k++) begin
      send_message(CMD_DELIVER, 3'd7, SEQ_W'(k), $urandom);
    end
    send_message(CMD_DELIVER, 3'd7, 16'd0, $urandom);
    steady = 1'b0;
  endtask

  task automatic test_random_traffic;
    int               effective;
    int               kind;
    int               m;
    logic [SRC_W-1:0] src;
    effective = 0;
    while (effective < RANDOM_ITEMS) begin
      steady = (effective >= 60 && effective < 100);
      kind = $urandom_range(0, 99);
      src = SRC_W'($urandom_range(0, NUM_SOURCES - 1));
      if (kind < 70) begin
        m = ($urandom_range(0, 9) == 0) ? WINDOW : $urandom_range(1, 6);
        send_shuffled_run(src, m);
        effective += m;
      end else if (kind < 82) begin
        // Noise: almost always stale or too far ahead.
        send_message(CMD_DELIVER, src, SEQ_W'($urandom), $urandom);
      end else if (kind < 93) begin
        send_message(CMD_DELIVER, src,
                     SEQ_W'(next_seq[src] + $urandom_range(1, WINDOW - 1)), $urandom);
        effective++;
      end else begin
        send_message(CMD_JOIN, src, SEQ_W'($urandom), $urandom);
        effective++;
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
  end

  // Result checker.
  always @(posedge clk) begin
    release_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_releases.size() == 0) begin
        flag_mismatch("unexpected result payload", 64'(out_payload), 64'd0);
      end else begin
        want = pending_releases[0];
        pending_releases.delete(0);
        if (out_source !== want.src) begin
          flag_mismatch("out_source", 64'(out_source), 64'(want.src));
        end
        if (global_seq !== want.stamp) begin
          flag_mismatch("global_seq", 64'(global_seq), 64'(want.stamp));
        end
        if (out_payload !== want.data) begin
          flag_mismatch("out_payload", 64'(out_payload), 64'(want.data));
        end
        if (last !== want.last) begin
          flag_mismatch("last", 64'(last), 64'(want.last));
        end
      end
    end
  end

  // Watchdog on cycles with no accepted transaction on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clear_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_in_order();
    test_reorder_and_overwrite();
    test_stale_and_far();
    test_join();
    test_full_window();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_releases.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[per_source_reorder_sequencer.f]
hdl/psrs_pkg.sv
hdl/psrs_ram.sv
hdl/psrs_front.sv
hdl/psrs_back.sv
hdl/per_source_reorder_sequencer.sv
tb/sv/per_source_reorder_sequencer_test.sv
